[src/cdn_pkg.sv]
// shared types, constants and the month table for the calendar day number pipeline
// no dependencies

package cdn_pkg;

    // day count constants
    localparam logic signed [15:0] GREG_YEAR       = 16'sd1582;
    localparam logic signed [26:0] DAY_BASE        = 27'sd694025;
    localparam logic signed [26:0] JD_OFFSET       = 27'sd2415020;
    localparam logic signed [26:0] DAYS_1980       = 27'sd29220;
    localparam logic signed [26:0] DAYS_1989_OCT1  = 27'sd32781;
    localparam logic signed [26:0] YEAR_MULT       = 27'sd1461;
    localparam logic        [26:0] DIV100_MULT     = 27'd5243;
    localparam int                 DIV100_SHIFT    = 19;
    localparam logic signed [34:0] HALF_MIN_PER_DAY = 35'sd2880;
    localparam logic        [12:0] HALF_DAY        = 13'd1440;

    // epoch selector codes on the input
    localparam logic signed [14:0] EPOCH_1980 = 15'sd1980;
    localparam logic signed [14:0] EPOCH_1900 = 15'sd1900;
    localparam logic signed [14:0] EPOCH_ZERO = 15'sd0;
    localparam logic signed [14:0] EPOCH_1989 = 15'sd1989;
    localparam logic signed [14:0] EPOCH_JD_A = -15'sd4000;
    localparam logic signed [14:0] EPOCH_JD_B = -15'sd4713;

    typedef enum logic [2:0] {
        EP_1980,
        EP_1900,
        EP_ZERO,
        EP_1989,
        EP_JD,
        EP_YEAR
    } epoch_sel_t;

    // floor(30.6001 * (m + 1))
    function automatic logic [9:0] month_term(input logic [3:0] m);
        logic [9:0] t;
        case (m)
            4'd0:  t = 10'd30;
            4'd1:  t = 10'd61;
            4'd2:  t = 10'd91;
            4'd3:  t = 10'd122;
            4'd4:  t = 10'd153;
            4'd5:  t = 10'd183;
            4'd6:  t = 10'd214;
            4'd7:  t = 10'd244;
            4'd8:  t = 10'd275;
            4'd9:  t = 10'd306;
            4'd10: t = 10'd336;
            4'd11: t = 10'd367;
            4'd12: t = 10'd397;
            4'd13: t = 10'd428;
            4'd14: t = 10'd459;
            4'd15: t = 10'd489;
        endcase
        return t;
    endfunction

    // day offset of january 1 within its (shifted) year: day 1 plus month 13 term
    localparam logic signed [26:0] JAN_FIRST = 27'(month_term(4'd13)) + 27'sd1;

    // after normalizing the date and epoch
    typedef struct packed {
        logic signed [15:0] y;
        logic               greg;
        logic [4:0]         day;
        logic [9:0]         mterm;
        logic signed [15:0] ey;
        logic               egreg;
        epoch_sel_t         esel;
        logic [11:0]        tod;
    } prep_t;

    // after the constant multiplies
    typedef struct packed {
        logic               y_neg;
        logic               greg;
        logic signed [26:0] py;
        logic [26:0]        ay;
        logic               ey_neg;
        logic               egreg;
        logic signed [26:0] epy;
        logic [26:0]        eay;
        logic [4:0]         day;
        logic [9:0]         mterm;
        epoch_sel_t         esel;
        logic [11:0]        tod;
    } mul_t;

    // year and gregorian terms
    typedef struct packed {
        logic signed [26:0] yt;
        logic signed [9:0]  corr;
        logic signed [26:0] eyt;
        logic signed [9:0]  ecorr;
        logic [4:0]         day;
        logic [9:0]         mterm;
        epoch_sel_t         esel;
        logic [11:0]        tod;
    } terms_t;

    // day counts of the date and of the epoch
    typedef struct packed {
        logic signed [26:0] d;
        logic signed [26:0] e;
        logic               half;
        logic [11:0]        tod;
    } days_t;

endpackage

[src/cdn_prep.sv]
// first stage: month shift, bc year fix, gregorian test, epoch decode, time of day
// depends on cdn_pkg

module cdn_prep
    import cdn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [14:0] year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    input  logic [4:0]         hour,
    input  logic [5:0]         minute,
    input  logic signed [14:0] epoch_year,
    output logic               out_valid,
    input  logic               out_ready,
    output prep_t              out_data
);

    logic  valid_reg;
    prep_t data_reg;
    prep_t data_next;

    logic               early;
    logic signed [15:0] y;
    logic signed [15:0] ey;
    logic [3:0]         m;

    always_comb
    begin
        early = month < 4'd3;
        y = 16'(year) - (early ? 16'sd1 : 16'sd0) + (year[14] ? 16'sd1 : 16'sd0);
        m = early ? month + 4'd12 : month;
        // a plain year epoch is january 1, so month 13 of the year before
        ey = epoch_year[14] ? 16'(epoch_year) : 16'(epoch_year) - 16'sd1;

        data_next.y     = y;
        data_next.greg  = (y > GREG_YEAR)
                       || (y == GREG_YEAR && (m > 4'd10 || (m == 4'd10 && day > 5'd15)));
        data_next.day   = day;
        data_next.mterm = month_term(m);
        data_next.ey    = ey;
        data_next.egreg = ey >= GREG_YEAR;
        data_next.tod   = (12'(hour) << 7) - (12'(hour) << 3) + 12'({minute, 1'b0});

        unique case (epoch_year) inside
            EPOCH_1980:             data_next.esel = EP_1980;
            EPOCH_1900:             data_next.esel = EP_1900;
            EPOCH_ZERO:             data_next.esel = EP_ZERO;
            EPOCH_1989:             data_next.esel = EP_1989;
            EPOCH_JD_A, EPOCH_JD_B: data_next.esel = EP_JD;
            default:                data_next.esel = EP_YEAR;
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[src/cdn_days.sv]
// three stages: year multiplies, year and gregorian terms, day count sums and epoch select
// depends on cdn_pkg

module cdn_days
    import cdn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  prep_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output days_t out_data
);

    logic   v1_reg, v2_reg, v3_reg;
    logic   rdy1, rdy2, rdy3;
    mul_t   s1_reg, s1_next;
    terms_t s2_reg, s2_next;
    days_t  s3_reg, s3_next;

    logic [7:0]         a;
    logic [7:0]         ea;
    logic signed [26:0] ny;
    logic signed [26:0] eny;
    logic signed [26:0] e_year;

    // multiplies by 1461 and by the reciprocal of 100
    always_comb
    begin
        s1_next.y_neg  = in_data.y[15];
        s1_next.greg   = in_data.greg;
        s1_next.py     = 27'(in_data.y) * YEAR_MULT;
        s1_next.ay     = 27'(in_data.y[13:0]) * DIV100_MULT;
        s1_next.ey_neg = in_data.ey[15];
        s1_next.egreg  = in_data.egreg;
        s1_next.epy    = 27'(in_data.ey) * YEAR_MULT;
        s1_next.eay    = 27'(in_data.ey[13:0]) * DIV100_MULT;
        s1_next.day    = in_data.day;
        s1_next.mterm  = in_data.mterm;
        s1_next.esel   = in_data.esel;
        s1_next.tod    = in_data.tod;
    end

    // bc years round the quarter toward zero after offsetting by 3
    always_comb
    begin
        a   = s1_reg.ay[DIV100_SHIFT +: 8];
        ea  = s1_reg.eay[DIV100_SHIFT +: 8];
        ny  = 27'sd3 - s1_reg.py;
        eny = 27'sd3 - s1_reg.epy;

        s2_next.yt    = s1_reg.y_neg ? -(ny >>> 2) : (s1_reg.py >>> 2);
        s2_next.eyt   = s1_reg.ey_neg ? -(eny >>> 2) : (s1_reg.epy >>> 2);
        s2_next.corr  = s1_reg.greg
                      ? 10'sd2 - $signed({2'b00, a}) + $signed({4'b0000, a[7:2]})
                      : 10'sd0;
        s2_next.ecorr = s1_reg.egreg
                      ? 10'sd2 - $signed({2'b00, ea}) + $signed({4'b0000, ea[7:2]})
                      : 10'sd0;
        s2_next.day   = s1_reg.day;
        s2_next.mterm = s1_reg.mterm;
        s2_next.esel  = s1_reg.esel;
        s2_next.tod   = s1_reg.tod;
    end

    always_comb
    begin
        s3_next.d = s2_reg.yt + 27'(s2_reg.corr) + $signed({22'b0, s2_reg.day})
                  + $signed({17'b0, s2_reg.mterm}) - DAY_BASE;
        e_year    = s2_reg.eyt + 27'(s2_reg.ecorr) + JAN_FIRST - DAY_BASE;

        unique case (s2_reg.esel)
            EP_1980: s3_next.e = DAYS_1980;
            EP_1900: s3_next.e = 27'sd0;
            EP_ZERO: s3_next.e = -DAY_BASE;
            EP_1989: s3_next.e = DAYS_1989_OCT1;
            EP_JD:   s3_next.e = -JD_OFFSET;
            default: s3_next.e = e_year;
        endcase

        s3_next.half = (s2_reg.esel == EP_1989) || (s2_reg.esel == EP_YEAR);
        s3_next.tod  = s2_reg.tod;
    end

    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

endmodule

[src/cdn_scale.sv]
// three stages: day difference, scale to half minutes, add time of day and the half-day bias where selected
// depends on cdn_pkg

module cdn_scale
    import cdn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  days_t              in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [34:0] result
);

    logic               v1_reg, v2_reg, v3_reg;
    logic               rdy1, rdy2, rdy3;
    logic signed [26:0] diff_reg, diff_next;
    logic [12:0]        bias1_reg, bias1_next;
    logic signed [34:0] prod_reg, prod_next;
    logic [12:0]        bias2_reg;
    logic signed [34:0] result_reg, result_next;

    always_comb
    begin
        diff_next   = in_data.d - in_data.e;
        bias1_next  = in_data.half ? HALF_DAY + 13'(in_data.tod) : 13'(in_data.tod);
        // wraps modulo 2^35
        prod_next   = 35'(diff_reg) * HALF_MIN_PER_DAY;
        result_next = prod_reg + $signed(35'(bias2_reg));
    end

    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v3_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            diff_reg  <= diff_next;
            bias1_reg <= bias1_next;
        end
        if (rdy2 && v1_reg)
        begin
            prod_reg  <= prod_next;
            bias2_reg <= bias1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            result_reg <= result_next;
        end
    end

endmodule

[src/calendar_to_day_number_top.sv]
// an accepted transaction moves through the 7 stage registers to its result on the output register
// throughput: one transaction per cycle unless the output stalls, set by per-stage valid bits
// the input stalls only when every stage holds a transaction and the output is stalled
// reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset
// top level of the calendar date to half-minute elapsed time converter
// depends on cdn_pkg, cdn_prep, cdn_days, cdn_scale

module calendar_to_day_number_top
    import cdn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input transaction
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [14:0] year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    input  logic [4:0]         hour,
    input  logic [5:0]         minute,
    input  logic signed [14:0] epoch_year,
    // result transaction
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [34:0] elapsed_half_minutes
);

    // handshake between the three pipeline sections
    logic  prep_in_ready;
    logic  prep_valid;
    logic  days_in_ready;
    prep_t prep_data;
    logic  days_valid;
    logic  scale_in_ready;
    days_t days_data;

    // a stage takes a new transaction when it is empty or its successor moves
    assign item_stall = !prep_in_ready;

    // stage 1: normalize the date (jan/feb become months 13/14 of the year
    // before, bc years move up by one), gregorian test, epoch decode, time of day
    cdn_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item_valid),
        .in_ready   (prep_in_ready),
        .year       (year),
        .month      (month),
        .day        (day),
        .hour       (hour),
        .minute     (minute),
        .epoch_year (epoch_year),
        .out_valid  (prep_valid),
        .out_ready  (days_in_ready),
        .out_data   (prep_data)
    );

    // stages 2 to 4: day count of the date and of the epoch in parallel
    // (constant multiplies, quarter-year and century terms, final sums and epoch select)
    cdn_days u_days (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (days_in_ready),
        .in_data   (prep_data),
        .out_valid (days_valid),
        .out_ready (scale_in_ready),
        .out_data  (days_data)
    );

    // stages 5 to 7: difference, times 2880, plus time of day and, for the 1989 and plain year
    // epochs, half a day; the last stage is the output register
    cdn_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (days_valid),
        .in_ready  (scale_in_ready),
        .in_data   (days_data),
        .out_valid (result_valid),
        .out_ready (!result_stall),
        .result    (elapsed_half_minutes)
    );

endmodule

[src/cdn_checker.sv]
// port-level checks on the calendar day number pipeline, bound to the top level
// no dependencies

module cdn_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic signed [14:0] year,
    input logic [3:0]         month,
    input logic [4:0]         day,
    input logic [4:0]         hour,
    input logic [5:0]         minute,
    input logic signed [14:0] epoch_year,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [34:0] elapsed_half_minutes
);

    // no result while in reset
    assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // a stalled result stays and holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(elapsed_half_minutes))
        else $error("stalled result changed");

    // back pressure on the input only comes from a stalled result with a full pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without output back pressure");

    // a stalled input transaction stays offered with the same fields
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(year) && $stable(month)
            && $stable(day) && $stable(hour) && $stable(minute) && $stable(epoch_year))
        else $error("stalled input transaction changed");

endmodule

bind calendar_to_day_number_top cdn_checker u_cdn_checker (.*);

[tb/sv/tb_calendar_to_day_number_top.sv]
// testbench for calendar_to_day_number_top: directed and random dates, each result checked
// against an in-bench model of the day count and epoch arithmetic
// depends on cdn_pkg (epoch selector codes) and the rtl under src

module tb_calendar_to_day_number_top;
    import cdn_pkg::*;

    // arithmetic constants of the conversion, kept independent of the rtl
    localparam longint HALF_MINUTES_PER_DAY = 2880;
    localparam longint DAYS_ZERO_TO_1900    = 694025;
    localparam longint DAYS_1900_TO_1980    = 29220;
    localparam longint JD_OF_1900           = 2415020;
    localparam longint GREGORIAN_YEAR       = 1582;

    // run limits: the whole run is 862 transactions
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 30;
    localparam int LONG_HOLD    = 300;

    // one input transaction
    typedef struct {
        logic signed [14:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic signed [14:0] epoch_year;
    } cal_date_t;

    // a date waiting for its elapsed time to come out of the pipeline
    typedef struct {
        cal_date_t          date;
        logic signed [34:0] elapsed;
    } pending_elapsed_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic signed [14:0] epoch_year;
    logic               result_valid;
    logic               result_stall;
    logic signed [34:0] elapsed_half_minutes;

    pending_elapsed_t elapsed_due[$];

    int send_gap_max;       // longest idle gap of the date sender
    int recv_gap_max;       // longest stall of the result receiver
    int long_hold_cycles;   // when set, the receiver's next stall lasts this long
    int cycle_count;
    int dates_sent;
    int results_checked;
    int mismatches;
    int input_stall_cycles; // cycles where the block held off an offered date

    calendar_to_day_number_top i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .item_valid           (item_valid),
        .item_stall           (item_stall),
        .year                 (year),
        .month                (month),
        .day                  (day),
        .hour                 (hour),
        .minute               (minute),
        .epoch_year           (epoch_year),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .elapsed_half_minutes (elapsed_half_minutes)
    );

    // clock, period 10
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // whole day count of a date relative to the 1900 base
    // jan and feb belong to the year before as months 13 and 14, bc years skip year zero,
    // and the gregorian correction starts strictly after 15 oct 1582
    function automatic longint days_since_1900(longint yr, longint mon, longint dy);
        longint y;
        longint m;
        longint a;
        longint cnt;
        cnt = 0;
        if (mon < 3)
        begin
            y = yr - 1;
            m = mon + 12;
        end
        else
        begin
            y = yr;
            m = mon;
        end
        if (yr < 0)
            y = y + 1;
        if (y > GREGORIAN_YEAR || (y == GREGORIAN_YEAR && m > 10)
                || (y == GREGORIAN_YEAR && m == 10 && dy > 15))
        begin
            a = y / 100;
            cnt = 2 - a + a / 4;
        end
        // division truncates toward zero, so negative years need their own rounding
        if (y < 0)
            cnt = cnt - (3 - 1461 * y) / 4;
        else
            cnt = cnt + (1461 * y) / 4;
        cnt = cnt - DAYS_ZERO_TO_1900 + dy + (306001 * (m + 1)) / 10000;
        return cnt;
    endfunction

    // elapsed half minutes from the selected epoch, wrapped to the 35-bit output
    function automatic logic signed [34:0] elapsed_from_epoch(cal_date_t c);
        longint d;
        longint tod;
        longint r;
        d = days_since_1900(longint'(c.year), longint'(c.month), longint'(c.day));
        tod = 120 * longint'(c.hour) + 2 * longint'(c.minute);
        case (c.epoch_year)
            EPOCH_1980:
                r = HALF_MINUTES_PER_DAY * (d - DAYS_1900_TO_1980) + tod;
            EPOCH_1900:
                r = HALF_MINUTES_PER_DAY * d + tod;
            EPOCH_ZERO:
                r = HALF_MINUTES_PER_DAY * (d + DAYS_ZERO_TO_1900) + tod;
            EPOCH_1989:
                r = HALF_MINUTES_PER_DAY * (d - days_since_1900(1989, 10, 1))
                    + HALF_MINUTES_PER_DAY / 2 + tod;
            EPOCH_JD_A, EPOCH_JD_B:
                r = HALF_MINUTES_PER_DAY * (d + JD_OF_1900) + tod;
            default:
                r = HALF_MINUTES_PER_DAY * (d - days_since_1900(longint'(c.epoch_year), 1, 1))
                    + HALF_MINUTES_PER_DAY / 2 + tod;
        endcase
        return r[34:0];
    endfunction

    function automatic cal_date_t make_date(int yr, int mon, int dy, int hr, int mi, int ep);
        cal_date_t c;
        c.year       = 15'(yr);
        c.month      = 4'(mon);
        c.day        = 5'(dy);
        c.hour       = 5'(hr);
        c.minute     = 6'(mi);
        c.epoch_year = 15'(ep);
        return c;
    endfunction

    // mostly well-formed dates, some near the calendar corners, some raw bit patterns
    function automatic cal_date_t random_date();
        cal_date_t c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            c.year   = 15'(int'($urandom_range(0, 14712)) - 4713);
            c.month  = 4'($urandom_range(1, 12));
            c.day    = 5'($urandom_range(1, 31));
            c.hour   = 5'($urandom_range(0, 23));
            c.minute = 6'($urandom_range(0, 59));
        end
        else if (pick < 85)
        begin
            // around the gregorian cutover or around the missing year zero
            if ($urandom_range(0, 1))
                c.year = 15'(int'($urandom_range(1581, 1583)));
            else
                c.year = 15'(int'($urandom_range(0, 4)) - 2);
            c.month  = 4'($urandom_range(1, 12));
            c.day    = 5'($urandom_range(1, 31));
            c.hour   = 5'($urandom_range(0, 23));
            c.minute = 6'($urandom_range(0, 59));
        end
        else
        begin
            c.year   = 15'($urandom);
            c.month  = 4'($urandom);
            c.day    = 5'($urandom);
            c.hour   = 5'($urandom);
            c.minute = 6'($urandom);
        end
        case ($urandom_range(0, 9))
            0: c.epoch_year = EPOCH_1980;
            1: c.epoch_year = EPOCH_1900;
            2: c.epoch_year = EPOCH_ZERO;
            3: c.epoch_year = EPOCH_1989;
            4: c.epoch_year = EPOCH_JD_A;
            5: c.epoch_year = EPOCH_JD_B;
            6, 7: c.epoch_year = 15'(int'($urandom_range(0, 14712)) - 4713);
            default: c.epoch_year = 15'($urandom);
        endcase
        return c;
    endfunction

    // offer one date after a random idle gap and hold it until the block takes it;
    // called right after the previous acceptance, so valid only drops when a gap follows
    task automatic send_date(input cal_date_t c);
        int gap;
        pending_elapsed_t p;
        gap = $urandom_range(0, send_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        year       <= c.year;
        month      <= c.month;
        day        <= c.day;
        hour       <= c.hour;
        minute     <= c.minute;
        epoch_year <= c.epoch_year;
        do
        begin
            @(posedge clk);
            if (item_stall)
                input_stall_cycles++;
        end
        while (item_stall);
        // transaction accepted at this edge
        p.date    = c;
        p.elapsed = elapsed_from_epoch(c);
        elapsed_due.push_back(p);
        dates_sent++;
    endtask

    // every named epoch plus a plain year, one date each
    task automatic test_each_epoch();
        send_date(make_date(2024, 6, 15, 12, 30, EPOCH_1980));
        send_date(make_date(1900, 1, 1, 0, 0, EPOCH_1900));
        send_date(make_date(1, 3, 1, 23, 59, EPOCH_ZERO));
        send_date(make_date(1989, 10, 1, 0, 0, EPOCH_1989));
        send_date(make_date(-4713, 1, 1, 12, 0, EPOCH_JD_A));
        send_date(make_date(2000, 2, 29, 6, 7, EPOCH_JD_B));
        send_date(make_date(2001, 1, 1, 0, 0, 2001));
    endtask

    // gregorian cutover, jan/feb shift to the year before, bc years and year zero
    task automatic test_calendar_corners();
        send_date(make_date(1582, 10, 15, 0, 0, EPOCH_1900));
        send_date(make_date(1582, 10, 16, 0, 0, EPOCH_1900));
        send_date(make_date(1582, 11, 1, 0, 0, EPOCH_1900));
        send_date(make_date(1583, 2, 1, 0, 0, EPOCH_1900));
        send_date(make_date(-1, 12, 31, 0, 0, EPOCH_ZERO));
        send_date(make_date(-1, 1, 1, 0, 0, -1));
        send_date(make_date(0, 1, 1, 0, 0, 0));
    endtask

    // fields beyond the calendar: month 0, 13 and 15, day 0, hour and minute overflow,
    // year extremes of the 15-bit field, which wrap the 35-bit result
    task automatic test_out_of_range_fields();
        send_date(make_date(2000, 0, 10, 0, 0, EPOCH_1980));
        send_date(make_date(2000, 13, 10, 0, 0, EPOCH_1980));
        send_date(make_date(2000, 15, 0, 31, 63, EPOCH_1980));
        send_date(make_date(9999, 12, 31, 23, 59, -4713));
        send_date(make_date(-4713, 1, 1, 0, 0, 9999));
        send_date(make_date(16383, 15, 31, 31, 63, -16384));
        send_date(make_date(-16384, 0, 0, 0, 0, 16383));
        send_date(make_date(-16384, 1, 1, 0, 0, EPOCH_1989));
    endtask

    // random dates under four idling patterns of sender and receiver
    task automatic test_random_traffic();
        send_gap_max = 19;
        recv_gap_max = 19;
        repeat (200) send_date(random_date());
        send_gap_max = 0;
        recv_gap_max = 0;
        repeat (200) send_date(random_date());
        send_gap_max = 0;
        recv_gap_max = 19;
        repeat (200) send_date(random_date());
        send_gap_max = 19;
        recv_gap_max = 0;
        repeat (200) send_date(random_date());
    endtask

    // receiver holds off for a long stretch while dates keep coming back to back,
    // so the pipeline fills and the input stalls
    task automatic test_full_pipeline_stall();
        send_gap_max = 0;
        recv_gap_max = 3;
        long_hold_cycles = LONG_HOLD;
        repeat (40) send_date(random_date());
        send_gap_max = 5;
    endtask

    // result receiver and checker: stalls at random, then takes one transaction
    // and compares it with the oldest date still waiting
    initial
    begin
        int hold;
        pending_elapsed_t p;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_cycles > 0)
                hold = long_hold_cycles;
            else
                hold = $urandom_range(0, recv_gap_max);
            long_hold_cycles = 0;
            @(negedge clk);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            if (elapsed_due.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %0d", $time,
                         elapsed_half_minutes);
                mismatches++;
            end
            else
            begin
                p = elapsed_due.pop_front();
                results_checked++;
                if (elapsed_half_minutes !== p.elapsed)
                begin
                    $display("%0t elapsed_half_minutes for %0d-%0d-%0d %0d:%0d epoch %0d:",
                             $time, p.date.year, p.date.month, p.date.day, p.date.hour,
                             p.date.minute, p.date.epoch_year);
                    $display("    expected %0d, actual %0d", p.elapsed,
                             elapsed_half_minutes);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     elapsed_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // reset, then the tests in turn, then drain and report
    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        year         = '0;
        month        = '0;
        day          = '0;
        hour         = '0;
        minute       = '0;
        epoch_year   = '0;
        send_gap_max = 5;
        recv_gap_max = 5;
        long_hold_cycles   = 0;
        cycle_count        = 0;
        dates_sent         = 0;
        results_checked    = 0;
        mismatches         = 0;
        input_stall_cycles = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_each_epoch();
        test_calendar_corners();
        test_out_of_range_fields();
        test_random_traffic();
        test_full_pipeline_stall();

        @(negedge clk);
        item_valid <= 1'b0;
        while (elapsed_due.size() != 0)
            @(posedge clk);
        // room for any stray result behind the last one
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d dates converted and checked (%0d mismatches): all epoch selectors,",
                 results_checked, mismatches);
        $display("gregorian cutover, bc years, odd fields, wrap, %0d cycles of input stall",
                 input_stall_cycles);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
